// ----- src/fcba_pkg.sv -----
// ----------------------------------------------------------------------------
// fcba_pkg: shared constants of the block-chain allocator
// Command and status codes and the default sizes of the tables.
// ----------------------------------------------------------------------------
package fcba_pkg;

    localparam int BLOCK_COUNT_DEF      = 256;
    localparam int DIR_ENTRIES_DEF      = 32;
    localparam int BLOCK_BYTES_LOG2_DEF = 10;

    localparam logic [2:0] CMD_FORMAT = 3'd0;
    localparam logic [2:0] CMD_SAVE   = 3'd1;
    localparam logic [2:0] CMD_OPEN   = 3'd2;
    localparam logic [2:0] CMD_CLOSE  = 3'd3;
    localparam logic [2:0] CMD_LIST   = 3'd4;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_UNFORMATTED  = 3'd1;
    localparam logic [2:0] ST_ALREADY_OPEN = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND    = 3'd3;
    localparam logic [2:0] ST_NO_SPACE     = 3'd4;
    localparam logic [2:0] ST_DIR_FULL     = 3'd5;
    localparam logic [2:0] ST_NAME_EXISTS  = 3'd6;

    localparam int NAME_BITS = 160;
    localparam int IN_BITS   = 3 + NAME_BITS + 18 + 5;    // 186
    localparam int IN_BYTES  = (IN_BITS + 7) / 8;         // 24
    localparam int OUT_BITS  = 3 + 5 + 8 + 18 + 1 + NAME_BITS;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;        // 25

endpackage

// ----- src/fat_chain_block_allocator_core.sv -----
// ----------------------------------------------------------------------------
// fat_chain_block_allocator_core: FAT-style block allocator with a directory
// Keeps a next-block table and a small file directory and runs five commands.
// ----------------------------------------------------------------------------
// Usage. One command item enters on the s_ stream (tdata packs cmd, the three
// name words, byte_length and entry_index from the low bit up) and exactly one
// result item leaves on the m_ stream (status, slot, start_block, listed_size,
// entry_valid and the listed name). The block works on one item at a time: a
// small sequencer drives one read and one write port on the table and on the
// directory, and every visit to an entry takes an address state and a check
// state. Format writes one table entry a cycle. Save scans the directory,
// counts free blocks and walks the table a second time to link the chain.
// Open scans the directory; close and the early error answers are decided
// when the item is accepted. s_tready is high only while the sequencer is
// idle and the output register is empty, so a stalled receiver simply holds
// the result in the output register and new items wait. After reset the
// block is unformatted: save, open and list answer unformatted. Table
// contents are undefined until the first format, which writes every entry;
// no clearing pass runs at reset.
// ----------------------------------------------------------------------------
module fat_chain_block_allocator_core #(
    parameter int BLOCK_COUNT      = fcba_pkg::BLOCK_COUNT_DEF,
    parameter int DIR_ENTRIES      = fcba_pkg::DIR_ENTRIES_DEF,
    parameter int BLOCK_BYTES_LOG2 = fcba_pkg::BLOCK_BYTES_LOG2_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // cmd[2:0], name_lo[66:3], name_mid[130:67], name_hi[162:131],
    // byte_length[180:163], entry_index[185:181], zero fill above
    input  logic [fcba_pkg::IN_BYTES*8-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[2:0], slot[7:3], start_block[15:8], listed_size[33:16],
    // entry_valid[34], out_name_lo[98:35], out_name_mid[162:99],
    // out_name_hi[194:163], zero fill above
    output logic [fcba_pkg::OUT_BYTES*8-1:0] m_tdata
);

    localparam int BW  = $clog2(BLOCK_COUNT);
    localparam int CW  = BW + 1;
    localparam int DW  = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
    localparam int DCW = $clog2(DIR_ENTRIES + 1);
    localparam int LW  = BW + 2;                       // link: {free,last,index}
    localparam int NW  = 18 - BLOCK_BYTES_LOG2 + 1;    // block need width
    localparam int NB  = fcba_pkg::NAME_BITS;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_FMT     = 4'd1;
    localparam logic [3:0] S_DSCAN   = 4'd2;  // issue directory read
    localparam logic [3:0] S_DCHK    = 4'd3;  // compare directory read
    localparam logic [3:0] S_CNT     = 4'd4;  // issue table read for count
    localparam logic [3:0] S_CNTCHK  = 4'd5;
    localparam logic [3:0] S_LNK     = 4'd6;
    localparam logic [3:0] S_LNKCHK  = 4'd7;
    localparam logic [3:0] S_FIN     = 4'd8;
    localparam logic [3:0] S_LISTRD  = 4'd9;
    localparam logic [3:0] S_LISTOUT = 4'd10;

    // Table and directory storage; read data is registered.
    logic [LW-1:0]  chain_mem [BLOCK_COUNT];
    logic [NB-1:0]  dname_mem [DIR_ENTRIES];
    logic [BW-1:0]  dfirst_mem [DIR_ENTRIES];
    logic [17:0]    dbytes_mem [DIR_ENTRIES];
    logic [DIR_ENTRIES-1:0] dused_reg, dused_next;

    logic [LW-1:0]  chain_rd_reg;
    logic [NB-1:0]  dname_rd_reg;
    logic [BW-1:0]  dfirst_rd_reg;
    logic [17:0]    dbytes_rd_reg;

    logic [3:0]     state_reg, state_next;
    logic [2:0]     cmd_reg, cmd_next;
    logic [NB-1:0]  name_reg, name_next;
    logic [17:0]    len_reg, len_next;
    logic [4:0]     idx_reg, idx_next;
    logic [NW-1:0]  need_reg, need_next;
    logic [CW-1:0]  bi_reg, bi_next;
    logic [CW-1:0]  found_reg, found_next;
    logic [BW-1:0]  prev_reg, prev_next;
    logic           have_prev_reg, have_prev_next;
    logic [BW-1:0]  first_reg, first_next;
    logic [DCW-1:0] di_reg, di_next;
    logic [DW-1:0]  slot_reg, slot_next;
    logic           slot_ok_reg, slot_ok_next;
    logic [DW-1:0]  hit_reg, hit_next;
    logic           hit_ok_reg, hit_ok_next;

    logic           formatted_reg, formatted_next;
    logic           open_reg, open_next;
    logic [CW-1:0]  used_reg, used_next;
    logic [DCW-1:0] files_reg, files_next;

    logic           ovalid_reg, ovalid_next;
    logic [fcba_pkg::OUT_BYTES*8-1:0] odata_reg, odata_next;

    // Pending back-link from the previous chain block to the newest one.
    logic [BW-1:0]  link_from_reg, link_to_reg;
    logic           link_pend_reg;

    // Table port controls.
    logic           tw_en;
    logic [BW-1:0]  tw_addr;
    logic [LW-1:0]  tw_data;
    logic [BW-1:0]  tr_addr;
    logic           dw_en;
    logic [DW-1:0]  dw_addr;
    logic [DW-1:0]  dr_addr;

    // Incoming name with bytes after the first zero byte cleared.
    logic [NB-1:0]  in_name;
    logic [2:0]     in_cmd;
    logic           ended;
    logic [17:0]    in_len;
    logic [18:0]    need_full;
    logic [NW-1:0]  need_in;

    always_comb begin
        in_name = s_tdata[162:3];
        ended   = 1'b0;
        for (int k = 0; k < NB / 8; k++) begin
            if (ended) begin
                in_name[k*8 +: 8] = 8'd0;
            end else if (in_name[k*8 +: 8] == 8'd0) begin
                ended = 1'b1;
            end
        end
    end

    assign in_cmd    = s_tdata[2:0];
    assign in_len    = s_tdata[180:163];
    assign need_full = ({1'b0, in_len} + 19'((1 << BLOCK_BYTES_LOG2) - 1)) >> BLOCK_BYTES_LOG2;
    // A file takes at least one block, even when it is empty.
    assign need_in   = (need_full == 19'd0) ? NW'(1) : NW'(need_full);

    wire s_acc = s_tvalid && s_tready;
    wire m_acc = ovalid_reg && m_tready;
    assign s_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    wire chain_free = chain_rd_reg[LW-1];

    function automatic logic [fcba_pkg::OUT_BYTES*8-1:0] pack_out(
        input logic [2:0] st, input logic [4:0] sl, input logic [7:0] sb,
        input logic [17:0] sz, input logic ev, input logic [NB-1:0] nm);
        logic [fcba_pkg::OUT_BYTES*8-1:0] v;
        v = '0;
        v[2:0]    = st;
        v[7:3]    = sl;
        v[15:8]   = sb;
        v[33:16]  = sz;
        v[34]     = ev;
        v[194:35] = nm;
        return v;
    endfunction

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        name_next      = name_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        need_next      = need_reg;
        bi_next        = bi_reg;
        found_next     = found_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        first_next     = first_reg;
        di_next        = di_reg;
        slot_next      = slot_reg;
        slot_ok_next   = slot_ok_reg;
        hit_next       = hit_reg;
        hit_ok_next    = hit_ok_reg;
        formatted_next = formatted_reg;
        open_next      = open_reg;
        used_next      = used_reg;
        files_next     = files_reg;
        dused_next     = dused_reg;
        ovalid_next    = ovalid_reg && !m_acc;
        odata_next     = odata_reg;
        tw_en   = 1'b0;
        tw_addr = bi_reg[BW-1:0];
        tw_data = '0;
        tr_addr = bi_reg[BW-1:0];
        dw_en   = 1'b0;
        dw_addr = slot_reg;
        dr_addr = di_reg[DW-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    cmd_next    = in_cmd;
                    name_next   = in_name;
                    len_next    = in_len;
                    idx_next    = s_tdata[185:181];
                    need_next   = need_in;
                    bi_next     = '0;
                    di_next     = '0;
                    found_next  = '0;
                    slot_ok_next = 1'b0;
                    hit_ok_next  = 1'b0;
                    have_prev_next = 1'b0;
                    case (in_cmd)
                        fcba_pkg::CMD_FORMAT: begin
                            state_next = S_FMT;
                        end
                        fcba_pkg::CMD_CLOSE: begin
                            open_next   = 1'b0;
                            ovalid_next = 1'b1;
                            odata_next  = pack_out(fcba_pkg::ST_OK, '0, '0, '0, 1'b0, '0);
                        end
                        fcba_pkg::CMD_SAVE, fcba_pkg::CMD_OPEN, fcba_pkg::CMD_LIST: begin
                            if (!formatted_reg) begin
                                ovalid_next = 1'b1;
                                odata_next  = pack_out(fcba_pkg::ST_UNFORMATTED, '0, '0,
                                                       '0, 1'b0, '0);
                            end else if (in_cmd == fcba_pkg::CMD_LIST) begin
                                state_next = S_LISTRD;
                            end else if (in_cmd == fcba_pkg::CMD_OPEN && open_reg) begin
                                ovalid_next = 1'b1;
                                odata_next  = pack_out(fcba_pkg::ST_ALREADY_OPEN, '0, '0,
                                                       '0, 1'b0, '0);
                            end else if (in_cmd == fcba_pkg::CMD_SAVE &&
                                         (used_reg > CW'(BLOCK_COUNT) ||
                                          32'(need_in) >
                                          32'(BLOCK_COUNT) - 32'(used_reg))) begin
                                ovalid_next = 1'b1;
                                odata_next  = pack_out(fcba_pkg::ST_NO_SPACE, '0, '0,
                                                       '0, 1'b0, '0);
                            end else if (in_cmd == fcba_pkg::CMD_SAVE &&
                                         files_reg >= DCW'(DIR_ENTRIES)) begin
                                ovalid_next = 1'b1;
                                odata_next  = pack_out(fcba_pkg::ST_DIR_FULL, '0, '0,
                                                       '0, 1'b0, '0);
                            end else begin
                                state_next = S_DSCAN;
                            end
                        end
                        default: begin
                            ovalid_next = 1'b1;
                            odata_next  = pack_out(fcba_pkg::ST_OK, '0, '0, '0, 1'b0, '0);
                        end
                    endcase
                end
            end
            S_FMT: begin
                // Write one table entry a cycle; first two are reserved.
                tw_en   = 1'b1;
                tw_data = (bi_reg < CW'(2)) ? {1'b0, 1'b1, {BW{1'b0}}}
                                            : {1'b1, 1'b0, {BW{1'b0}}};
                bi_next = bi_reg + 1'b1;
                if (bi_reg == CW'(BLOCK_COUNT - 1)) begin
                    dused_next     = '0;
                    used_next      = CW'(2);
                    files_next     = '0;
                    formatted_next = 1'b1;
                    ovalid_next    = 1'b1;
                    odata_next     = pack_out(fcba_pkg::ST_OK, '0, '0, '0, 1'b0, '0);
                    state_next     = S_IDLE;
                end
            end
            S_DSCAN: begin
                dr_addr    = di_reg[DW-1:0];
                state_next = S_DCHK;
            end
            S_DCHK: begin
                // Registered read of slot di_reg is now visible.
                if (dused_reg[di_reg[DW-1:0]]) begin
                    if (!hit_ok_reg && dname_rd_reg == name_reg) begin
                        hit_ok_next = 1'b1;
                        hit_next    = di_reg[DW-1:0];
                    end
                end else if (!slot_ok_reg) begin
                    slot_ok_next = 1'b1;
                    slot_next    = di_reg[DW-1:0];
                end
                di_next = di_reg + 1'b1;
                if (di_reg == DCW'(DIR_ENTRIES - 1)) begin
                    if (cmd_reg == fcba_pkg::CMD_OPEN) begin
                        ovalid_next = 1'b1;
                        state_next  = S_IDLE;
                        if (hit_ok_next) begin
                            open_next  = 1'b1;
                            odata_next = pack_out(fcba_pkg::ST_OK, 5'(hit_next), '0, '0,
                                                  1'b0, '0);
                        end else begin
                            odata_next = pack_out(fcba_pkg::ST_NOT_FOUND, '0, '0, '0,
                                                  1'b0, '0);
                        end
                    end else if (hit_ok_next) begin
                        ovalid_next = 1'b1;
                        odata_next  = pack_out(fcba_pkg::ST_NAME_EXISTS, '0, '0, '0,
                                               1'b0, '0);
                        state_next  = S_IDLE;
                    end else if (!slot_ok_next) begin
                        ovalid_next = 1'b1;
                        odata_next  = pack_out(fcba_pkg::ST_DIR_FULL, '0, '0, '0,
                                               1'b0, '0);
                        state_next  = S_IDLE;
                    end else begin
                        bi_next    = CW'(2);
                        state_next = S_CNT;
                    end
                end else begin
                    state_next = S_DSCAN;
                end
            end
            S_CNT: begin
                if (bi_reg == CW'(BLOCK_COUNT) || found_reg == CW'(need_reg)) begin
                    if (found_reg < CW'(need_reg)) begin
                        ovalid_next = 1'b1;
                        odata_next  = pack_out(fcba_pkg::ST_NO_SPACE, '0, '0, '0,
                                               1'b0, '0);
                        state_next  = S_IDLE;
                    end else begin
                        bi_next    = CW'(2);
                        found_next = '0;
                        state_next = S_LNK;
                    end
                end else begin
                    tr_addr    = bi_reg[BW-1:0];
                    state_next = S_CNTCHK;
                end
            end
            S_CNTCHK: begin
                if (chain_free) begin
                    found_next = found_reg + 1'b1;
                end
                bi_next    = bi_reg + 1'b1;
                state_next = S_CNT;
            end
            S_LNK: begin
                if (found_reg == CW'(need_reg)) begin
                    state_next = S_FIN;
                end else begin
                    tr_addr    = bi_reg[BW-1:0];
                    state_next = S_LNKCHK;
                end
            end
            S_LNKCHK: begin
                if (chain_free) begin
                    // Mark this block last; the previous one is linked in S_FIN.
                    tw_en   = 1'b1;
                    tw_addr = bi_reg[BW-1:0];
                    tw_data = {1'b0, 1'b1, {BW{1'b0}}};
                    if (!have_prev_reg) begin
                        first_next = bi_reg[BW-1:0];
                    end
                    have_prev_next = 1'b1;
                    prev_next      = bi_reg[BW-1:0];
                    found_next     = found_reg + 1'b1;
                    state_next     = have_prev_reg ? S_FIN : S_LNK;
                end else begin
                    state_next = S_LNK;
                end
                bi_next = bi_reg + 1'b1;
            end
            S_FIN: begin
                if (link_pend_reg) begin
                    // Point the previous block at the block just taken.
                    tw_en      = 1'b1;
                    tw_addr    = link_from_reg;
                    tw_data    = {2'b00, link_to_reg};
                    state_next = (found_reg == CW'(need_reg)) ? S_FIN : S_LNK;
                end else begin
                    dw_en       = 1'b1;
                    dw_addr     = slot_reg;
                    dused_next[slot_reg] = 1'b1;
                    used_next   = used_reg + CW'(need_reg);
                    files_next  = files_reg + 1'b1;
                    ovalid_next = 1'b1;
                    odata_next  = pack_out(fcba_pkg::ST_OK, 5'(slot_reg), 8'(first_reg),
                                           '0, 1'b0, '0);
                    state_next  = S_IDLE;
                end
            end
            S_LISTRD: begin
                dr_addr    = DW'(idx_reg);
                state_next = S_LISTOUT;
            end
            S_LISTOUT: begin
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
                if (32'(idx_reg) < DIR_ENTRIES && dused_reg[DW'(idx_reg)]) begin
                    odata_next = pack_out(fcba_pkg::ST_OK, '0, 8'(dfirst_rd_reg),
                                          dbytes_rd_reg, 1'b1, dname_rd_reg);
                end else begin
                    odata_next = pack_out(fcba_pkg::ST_OK, '0, '0, '0, 1'b0, '0);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // When S_LNKCHK takes a block and an earlier block exists, the earlier
    // block must point at the new one. The table has one write port, so the
    // link is held here and written in the S_FIN cycle that follows.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_pend_reg <= 1'b0;
        end else begin
            link_pend_reg <= (state_reg == S_LNKCHK) && chain_free && have_prev_reg;
        end
        if (state_reg == S_LNKCHK) begin
            link_from_reg <= prev_reg;
            link_to_reg   <= bi_reg[BW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (tw_en) begin
            chain_mem[tw_addr] <= tw_data;
        end
        chain_rd_reg <= chain_mem[tr_addr];
        if (dw_en) begin
            dname_mem[dw_addr]  <= name_reg;
            dfirst_mem[dw_addr] <= first_reg;
            dbytes_mem[dw_addr] <= len_reg;
        end
        dname_rd_reg  <= dname_mem[dr_addr];
        dfirst_rd_reg <= dfirst_mem[dr_addr];
        dbytes_rd_reg <= dbytes_mem[dr_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            formatted_reg <= 1'b0;
            open_reg      <= 1'b0;
            used_reg      <= '0;
            files_reg     <= '0;
            ovalid_reg    <= 1'b0;
            dused_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            formatted_reg <= formatted_next;
            open_reg      <= open_next;
            used_reg      <= used_next;
            files_reg     <= files_next;
            ovalid_reg    <= ovalid_next;
            dused_reg     <= dused_next;
        end
        cmd_reg       <= cmd_next;
        name_reg      <= name_next;
        len_reg       <= len_next;
        idx_reg       <= idx_next;
        need_reg      <= need_next;
        bi_reg        <= bi_next;
        found_reg     <= found_next;
        prev_reg      <= prev_next;
        have_prev_reg <= have_prev_next;
        first_reg     <= first_next;
        di_reg        <= di_next;
        slot_reg      <= slot_next;
        slot_ok_reg   <= slot_ok_next;
        hit_reg       <= hit_next;
        hit_ok_reg    <= hit_ok_next;
        odata_reg     <= odata_next;
    end

    // A result is never overwritten while it waits to be taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("pending result changed");
    // No item is taken while the sequencer is busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE && !ovalid_reg)
        else $error("ready while busy");
    // Blocks in use never exceed the table size once formatted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        formatted_reg |-> used_reg <= CW'(BLOCK_COUNT))
        else $error("block count overflow");
    // A pending back-link write happens only right after the link check.
    assert property (@(posedge aclk) disable iff (!aresetn)
        link_pend_reg |-> state_reg == S_FIN)
        else $error("stray link write");

endmodule
